/* hdl/dbt_pkg.sv */
// Shared types and constants for the debounced toggle button controller.
package dbt_pkg;

  localparam int unsigned CountW  = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COUNT_LOW      = 2'd0,
    CFG_COUNT_HIGH     = 2'd1,
    CFG_LONG_PRESS_MS  = 2'd2,
    CFG_POWER_ON_RELAY = 2'd3
  } cfg_idx_e;

  localparam logic [CountW-1:0] CountLowRst    = 8'd0;
  localparam logic [CountW-1:0] CountHighRst   = 8'd10;
  localparam logic [TimeW-1:0]  LongPressMsRst = 32'd5000;
  localparam logic              PowerOnRst     = 1'b0;

  typedef struct packed {
    logic [CountW-1:0] count_low;
    logic [CountW-1:0] count_high;
    logic [TimeW-1:0]  long_press_ms;
    logic              power_on_relay;
    logic              relay_load;
  } cfg_t;

  typedef struct packed {
    logic button_level;
    logic [TimeW-1:0] now_ms;
    logic remote_write;
    logic remote_value;
  } item_t;

  typedef struct packed {
    logic relay_on;
    logic save_relay;
    logic pairing_request;
    logic pressed;
  } result_t;

endpackage

/* hdl/debounced_toggle_button_controller.sv */
// Top level: input request register, poll logic and result register.
// A request is held in the input register while the poll logic works on it, and its
// result is registered in the result register that drives the outputs.
// Throughput: one request per cycle unless the output is stalled; the input
// register and the result register let a new request enter while a finished result waits.
// Reset: asynchronous, active low; clears both stages and loads the default
// configuration, an integrator at the low bound and the relay off.
module debounced_toggle_button_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dbt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dbt_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        button_level_i,
  input  logic [dbt_pkg::TimeW-1:0]   now_ms_i,
  input  logic                        remote_write_i,
  input  logic                        remote_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        relay_on_o,
  output logic                        save_relay_o,
  output logic                        pairing_request_o,
  output logic                        pressed_o
);

  dbt_pkg::cfg_t    cfg;
  dbt_pkg::item_t   item_q;
  dbt_pkg::result_t result, result_q;
  logic             item_valid_q, out_valid_q;
  logic             out_free, step;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = item_valid_q && out_free;
  assign in_ready_o = !item_valid_q || step;

  dbt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dbt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .item_i     (item_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.button_level <= button_level_i;
      item_q.now_ms       <= now_ms_i;
      item_q.remote_write <= remote_write_i;
      item_q.remote_value <= remote_value_i;
    end
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign relay_on_o        = result_q.relay_on;
  assign save_relay_o      = result_q.save_relay;
  assign pairing_request_o = result_q.pairing_request;
  assign pressed_o         = result_q.pressed;

endmodule

/* hdl/dbt_cfg_regs.sv */
// Configuration register file of the debounced toggle button controller.
module dbt_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dbt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dbt_pkg::CfgW-1:0]    cfg_data_i,
  output dbt_pkg::cfg_t               cfg_o
);

  logic [dbt_pkg::CountW-1:0] count_low_q;
  logic [dbt_pkg::CountW-1:0] count_high_q;
  logic [dbt_pkg::TimeW-1:0]  long_press_ms_q;
  logic                       power_on_relay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_low_q      <= dbt_pkg::CountLowRst;
      count_high_q     <= dbt_pkg::CountHighRst;
      long_press_ms_q  <= dbt_pkg::LongPressMsRst;
      power_on_relay_q <= dbt_pkg::PowerOnRst;
    end else if (cfg_we_i) begin
      case (dbt_pkg::cfg_idx_e'(cfg_idx_i))
        dbt_pkg::CFG_COUNT_LOW:      count_low_q      <= cfg_data_i[dbt_pkg::CountW-1:0];
        dbt_pkg::CFG_COUNT_HIGH:     count_high_q     <= cfg_data_i[dbt_pkg::CountW-1:0];
        dbt_pkg::CFG_LONG_PRESS_MS:  long_press_ms_q  <= cfg_data_i[dbt_pkg::TimeW-1:0];
        dbt_pkg::CFG_POWER_ON_RELAY: power_on_relay_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.count_low      = count_low_q;
    cfg_o.count_high     = count_high_q;
    cfg_o.long_press_ms  = long_press_ms_q;
    cfg_o.power_on_relay = power_on_relay_q;
    // A write of the start-up value also loads the relay right away.
    cfg_o.relay_load     = cfg_we_i &&
                           (dbt_pkg::cfg_idx_e'(cfg_idx_i) == dbt_pkg::CFG_POWER_ON_RELAY);
  end

endmodule

/* hdl/dbt_core.sv */
// Debounce state and single-pass poll logic of the toggle button controller.
module dbt_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dbt_pkg::cfg_t             cfg_i,
  input  logic [dbt_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      step_i,
  input  dbt_pkg::item_t            item_i,
  output dbt_pkg::result_t          result_o
);

  logic [dbt_pkg::CountW-1:0] integ_q, integ_d;
  logic                       relay_q, relay_d;
  logic                       latched_q, latched_d;
  logic                       armed_q, armed_d;
  logic [dbt_pkg::TimeW-1:0]  start_q, start_d;

  logic                       press, release_hit, pairing, armed_mid;
  logic                       relay_mid;
  logic [dbt_pkg::TimeW-1:0]  elapsed;

  always_comb begin
    integ_d = integ_q;
    if (item_i.button_level && (integ_q < cfg_i.count_high)) begin
      integ_d = integ_q + 1'b1;
    end else if (!item_i.button_level && (integ_q > cfg_i.count_low)) begin
      integ_d = integ_q - 1'b1;
    end

    press     = (integ_d == cfg_i.count_high) && !latched_q;
    latched_d = latched_q | press;
    armed_mid = armed_q | press;
    start_d   = press ? item_i.now_ms : start_q;
    relay_mid = relay_q ^ press;

    // Press and release are tested in order, so equal bounds release at once.
    release_hit = (integ_d == cfg_i.count_low) && latched_d;
    if (release_hit) begin
      latched_d = 1'b0;
      armed_mid = 1'b0;
    end

    // Modulo subtraction keeps the hold time right across a time wrap.
    elapsed = item_i.now_ms - start_d;
    pairing = armed_mid && (elapsed > cfg_i.long_press_ms);
    armed_d = armed_mid && !pairing;

    relay_d = relay_mid;
    if (item_i.remote_write && !press && (item_i.remote_value != relay_mid)) begin
      relay_d = item_i.remote_value;
    end

    result_o.relay_on        = relay_d;
    result_o.save_relay      = press;
    result_o.pairing_request = pairing;
    result_o.pressed         = latched_d & armed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= dbt_pkg::CountLowRst;
      relay_q   <= dbt_pkg::PowerOnRst;
      latched_q <= 1'b0;
      armed_q   <= 1'b0;
      start_q   <= '0;
    end else if (cfg_i.relay_load) begin
      relay_q <= cfg_data_i[0];
    end else if (step_i) begin
      integ_q   <= integ_d;
      relay_q   <= relay_d;
      latched_q <= latched_d;
      armed_q   <= armed_d;
      start_q   <= start_d;
    end
  end

endmodule

/* hdl/dbt_checker.sv */
// Port-level checker for the debounced toggle button controller, with its bind.
module dbt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic relay_on_o,
  input logic save_relay_o,
  input logic pairing_request_o,
  input logic pressed_o
);

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(relay_on_o) &&
      $stable(save_relay_o) && $stable(pairing_request_o) && $stable(pressed_o))
    else $error("result changed while stalled");

  // Input back-pressure only comes from a result that is waiting.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with an empty output");

  // The pairing pulse disarms the timer, so it never shows with pressed.
  a_pair_not_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pairing_request_o |-> !pressed_o)
    else $error("pairing request with press still timed");

  // A fresh press starts the timer at zero, so it cannot fire the same poll.
  a_pair_not_save: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && save_relay_o |-> !pairing_request_o)
    else $error("pairing request in the toggling poll");

endmodule

bind debounced_toggle_button_controller dbt_checker u_dbt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .relay_on_o        (relay_on_o),
  .save_relay_o      (save_relay_o),
  .pairing_request_o (pairing_request_o),
  .pressed_o         (pressed_o)
);

/* tb/debounced_toggle_button_controller_test.sv */
// Self-checking testbench for the debounced toggle button controller.
`timescale 1ns / 100ps

module debounced_toggle_button_controller_test;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 4;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [dbt_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [dbt_pkg::CfgW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic button_level_i;
  logic [dbt_pkg::TimeW-1:0] now_ms_i;
  logic remote_write_i;
  logic remote_value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic relay_on_o;
  logic save_relay_o;
  logic pairing_request_o;
  logic pressed_o;

  debounced_toggle_button_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .button_level_i   (button_level_i),
    .now_ms_i         (now_ms_i),
    .remote_write_i   (remote_write_i),
    .remote_value_i   (remote_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .relay_on_o       (relay_on_o),
    .save_relay_o     (save_relay_o),
    .pairing_request_o(pairing_request_o),
    .pressed_o        (pressed_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mirror of the controller: configuration and poll state.
  logic [dbt_pkg::CountW-1:0] bound_lo;
  logic [dbt_pkg::CountW-1:0] bound_hi;
  logic [dbt_pkg::TimeW-1:0]  hold_limit_ms;
  logic [dbt_pkg::CountW-1:0] integ_cnt;
  logic                       relay_q;
  logic                       press_q;
  logic                       timer_q;
  logic [dbt_pkg::TimeW-1:0]  press_t0;

  dbt_pkg::result_t button_outputs_q[$];
  dbt_pkg::result_t want;
  logic [dbt_pkg::TimeW-1:0] now_track;
  bit gaps_on;
  bit stalls_on;
  int fail_count;
  int stall_left;
  int ready_roll;
  int unsigned quiet_cycles;

  function automatic dbt_pkg::result_t debounce_poll(dbt_pkg::item_t p);
    dbt_pkg::result_t r;
    logic [dbt_pkg::TimeW-1:0] elapsed;
    r = '0;
    if (p.button_level && integ_cnt < bound_hi) integ_cnt = integ_cnt + 1'b1;
    if (!p.button_level && integ_cnt > bound_lo) integ_cnt = integ_cnt - 1'b1;
    // Press is tested before release, so equal bounds toggle and release at once.
    if (integ_cnt == bound_hi && !press_q) begin
      timer_q = 1'b1;
      press_t0 = p.now_ms;
      relay_q = ~relay_q;
      r.save_relay = 1'b1;
      press_q = 1'b1;
    end
    if (integ_cnt == bound_lo && press_q) begin
      press_q = 1'b0;
      timer_q = 1'b0;
    end
    elapsed = p.now_ms - press_t0;
    if (timer_q && elapsed > hold_limit_ms) begin
      r.pairing_request = 1'b1;
      timer_q = 1'b0;
    end
    if (p.remote_write && !r.save_relay && p.remote_value != relay_q) relay_q = p.remote_value;
    r.relay_on = relay_q;
    r.pressed = press_q & timer_q;
    return r;
  endfunction

  task automatic push_poll(input dbt_pkg::item_t p);
    int gap;
    int roll;
    gap = 0;
    if (gaps_on) begin
      roll = $urandom_range(99);
      if (roll < 65) gap = 0;
      else if (roll < 95) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 10);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    button_level_i <= p.button_level;
    now_ms_i       <= p.now_ms;
    remote_write_i <= p.remote_write;
    remote_value_i <= p.remote_value;
    do @(posedge clk_i); while (!in_ready_o);
    button_outputs_q.push_back(debounce_poll(p));
  endtask

  task automatic poll(input bit lvl, input logic [dbt_pkg::TimeW-1:0] t, input bit rw,
                      input bit rv);
    dbt_pkg::item_t p;
    p.button_level = lvl;
    p.now_ms = t;
    p.remote_write = rw;
    p.remote_value = rv;
    push_poll(p);
  endtask

  // Lets every outstanding result come back with the request channel quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (button_outputs_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // The caller lowers the write enable once its writes are done.
  task automatic write_reg(input dbt_pkg::cfg_idx_e idx, input logic [dbt_pkg::CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      dbt_pkg::CFG_COUNT_LOW:      bound_lo = val[dbt_pkg::CountW-1:0];
      dbt_pkg::CFG_COUNT_HIGH:     bound_hi = val[dbt_pkg::CountW-1:0];
      dbt_pkg::CFG_LONG_PRESS_MS:  hold_limit_ms = val;
      dbt_pkg::CFG_POWER_ON_RELAY: relay_q = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [dbt_pkg::CountW-1:0] lo,
                              input logic [dbt_pkg::CountW-1:0] hi,
                              input logic [dbt_pkg::TimeW-1:0] lp);
    drain();
    write_reg(dbt_pkg::CFG_COUNT_LOW, ($urandom() & 32'hFFFF_FF00) | lo);
    write_reg(dbt_pkg::CFG_COUNT_HIGH, ($urandom() & 32'hFFFF_FF00) | hi);
    write_reg(dbt_pkg::CFG_LONG_PRESS_MS, lp);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_relay(input bit v);
    drain();
    write_reg(dbt_pkg::CFG_POWER_ON_RELAY, ($urandom() & 32'hFFFF_FFFE) | v);
    cfg_we_i <= 1'b0;
  endtask

  // Alternating press and release runs with some bounce, remote writes and time jumps.
  task automatic run_polls(input int n, input int run_max, input int unsigned max_step);
    int sent;
    int run_len;
    bit lvl;
    dbt_pkg::item_t p;
    sent = 0;
    lvl = 1'($urandom_range(1));
    while (sent < n) begin
      gaps_on = ($urandom_range(3) != 0);
      stalls_on = ($urandom_range(3) != 0);
      if ($urandom_range(7) == 0) run_len = $urandom_range(2, 1);
      else run_len = $urandom_range(run_max, (run_max + 1) / 2);
      for (int i = 0; i < run_len && sent < n; i++) begin
        p.button_level = ($urandom_range(15) == 0) ? !lvl : lvl;
        if ($urandom_range(63) == 0) now_track = $urandom();
        else now_track = now_track + $urandom_range(max_step);
        p.now_ms = now_track;
        p.remote_write = ($urandom_range(7) == 0);
        p.remote_value = 1'($urandom_range(1));
        push_poll(p);
        sent++;
        if ($urandom_range(127) == 0) drain();
      end
      lvl = !lvl;
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 10; i++) poll(1'b1, 32'd1000 + i, 1'b0, 1'b0);
    poll(1'b1, 32'd6010, 1'b0, 1'b0);
    for (int i = 0; i < 10; i++) poll(1'b0, 32'd6100 + i, 1'b0, 1'b0);
    now_track = 32'd6200;
  endtask

  task automatic test_directed_cases();
    apply_config(8'd0, 8'd3, 32'd100);
    poll(1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0);
    poll(1'b1, 32'hFFFF_FFF1, 1'b1, 1'b0);
    poll(1'b1, 32'hFFFF_FFF2, 1'b1, 1'b1);
    // The toggle and a differing remote write land in the same request.
    poll(1'b1, 32'hFFFF_FFF3, 1'b1, 1'b1);
    // Elapsed time wraps through zero: 93, 100 and then 101 ms.
    poll(1'b1, 32'h0000_0050, 1'b0, 1'b0);
    poll(1'b1, 32'h0000_0057, 1'b0, 1'b0);
    poll(1'b1, 32'h0000_0058, 1'b0, 1'b0);
    poll(1'b1, 32'hFFFF_0000, 1'b1, 1'b0);
    for (int i = 0; i < 3; i++) poll(1'b0, 32'hFFFF_0010 + i, 1'b0, 1'b0);
    poll(1'b0, 32'hFFFF_0020, 1'b1, 1'b1);
    poll(1'b0, 32'hFFFF_0021, 1'b1, 1'b1);
    apply_config(8'd0, 8'd0, 32'd50);
    poll(1'b0, 32'hFFFF_0030, 1'b0, 1'b0);
    poll(1'b1, 32'hFFFF_0031, 1'b1, 1'b0);
    poll(1'b0, 32'hFFFF_0032, 1'b0, 1'b0);
    now_track = 32'hFFFF_0040;
  endtask

  task automatic test_power_on_load();
    load_relay(1'b1);
    for (int i = 0; i < 3; i++) begin
      poll(1'($urandom_range(1)), now_track + i, 1'($urandom_range(1)), 1'b1);
    end
    load_relay(1'b0);
    for (int i = 0; i < 3; i++) begin
      poll(1'($urandom_range(1)), now_track + i, 1'($urandom_range(1)), 1'b0);
    end
  endtask

  task automatic test_extreme_bounds();
    apply_config(8'd0, 8'd255, 32'hFFFF_FFFF);
    for (int i = 0; i < 256; i++) begin
      now_track = ($urandom_range(31) == 0) ? $urandom() : now_track + $urandom_range(1000);
      poll(1'b1, now_track, $urandom_range(7) == 0, 1'($urandom_range(1)));
    end
    apply_config(8'd255, 8'd255, 32'd0);
    run_polls(60, 4, 3);
  endtask

  task automatic test_random_configs();
    int lo;
    int hi;
    int span;
    int unsigned lp;
    apply_config(8'd2, 8'd6, 32'd300);
    run_polls(290, 10, 80);
    apply_config(8'd0, 8'd1, 32'd0);
    run_polls(150, 3, 5);
    apply_config(8'd9, 8'd4, 32'd1000);
    run_polls(120, 10, 200);
    apply_config(8'd7, 8'd7, 32'd40);
    run_polls(120, 10, 20);
    apply_config(8'd0, 8'd0, 32'd25);
    run_polls(60, 4, 20);
    for (int k = 0; k < 2; k++) begin
      lo = $urandom_range(15);
      hi = $urandom_range(15);
      lp = $urandom_range(2000);
      span = (hi > lo) ? hi - lo : lo - hi;
      apply_config(lo[dbt_pkg::CountW-1:0], hi[dbt_pkg::CountW-1:0], lp);
      run_polls(150, span + 4, lp / (span + 1) + 10);
    end
  endtask

  // Result side: random back-pressure, occasionally long.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stalls_on) begin
      out_ready_i <= 1'b1;
    end else begin
      ready_roll = $urandom_range(99);
      if (ready_roll < 60) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        stall_left <= (ready_roll < 95) ? $urandom_range(2) : $urandom_range(39, 9);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (button_outputs_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = button_outputs_q.pop_front();
        if (relay_on_o !== want.relay_on) begin
          $error("relay_on: expected %0b, actual %0b", want.relay_on, relay_on_o);
          fail_count++;
        end
        if (save_relay_o !== want.save_relay) begin
          $error("save_relay: expected %0b, actual %0b", want.save_relay, save_relay_o);
          fail_count++;
        end
        if (pairing_request_o !== want.pairing_request) begin
          $error("pairing_request: expected %0b, actual %0b", want.pairing_request,
                 pairing_request_o);
          fail_count++;
        end
        if (pressed_o !== want.pressed) begin
          $error("pressed: expected %0b, actual %0b", want.pressed, pressed_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= dbt_pkg::CFG_COUNT_LOW;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    button_level_i <= 1'b0;
    now_ms_i       <= '0;
    remote_write_i <= 1'b0;
    remote_value_i <= 1'b0;
    out_ready_i    <= 1'b0;
    fail_count = 0;
    stall_left = 0;
    quiet_cycles = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    bound_lo = dbt_pkg::CountLowRst;
    bound_hi = dbt_pkg::CountHighRst;
    hold_limit_ms = dbt_pkg::LongPressMsRst;
    integ_cnt = dbt_pkg::CountLowRst;
    relay_q = dbt_pkg::PowerOnRst;
    press_q = 1'b0;
    timer_q = 1'b0;
    press_t0 = '0;
    now_track = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_directed_cases();
    test_power_on_load();
    test_extreme_bounds();
    test_random_configs();
    drain();

    if (fail_count == 0 && button_outputs_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
